@@ rtl/fdp_pkg.sv @@
`timescale 1ns / 1ps
package fdp_pkg;

  localparam int CHAR_W  = 8;
  localparam int ARG_W   = 16;
  localparam int MAG_W   = 16;
  localparam int NDIGITS = 5;
  localparam int BCD_W   = 4 * NDIGITS;
  localparam int CNT_W   = $clog2(MAG_W + 1);
  localparam int DCNT_W  = $clog2(NDIGITS + 1);

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;

  // finished conversion from the shift-and-add-3 unit
  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] bcd;
  } bcd_res_t;

  // one character offered by the digit sequencer
  typedef struct packed {
    logic              valid;
    logic              last;
    logic [CHAR_W-1:0] ch;
  } dig_out_t;

endpackage

@@ rtl/fdp_if.sv @@
`timescale 1ns / 1ps
interface fdp_in_if import fdp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CHAR_W-1:0]       fmt_char;
  logic signed [ARG_W-1:0] arg_value;

  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink (input valid, input fmt_char, input arg_value, output ready);
endinterface

interface fdp_out_if import fdp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink (input valid, input out_char, input last_of_run, output ready);
endinterface

@@ rtl/fdp_dabble.sv @@
`timescale 1ns / 1ps
module fdp_dabble import fdp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [MAG_W-1:0] mag_i,
  output bcd_res_t         res_o
);

  logic [MAG_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0] bcd_q, bcd_d, adj;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = mag_i;
      bcd_d  = '0;
      cnt_d  = CNT_W'(MAG_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[MAG_W-1]};
      bin_d = {bin_q[MAG_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign res_o.done = done_q;
  assign res_o.bcd  = bcd_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q))
    else $error("conversion finished without running");

  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && cnt_q == CNT_W'(MAG_W))
    else $error("conversion did not start");

endmodule

@@ rtl/fdp_digits.sv @@
`timescale 1ns / 1ps
module fdp_digits import fdp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  bcd_res_t res_i,
  input  logic     ready_i,
  output dig_out_t dig_o
);

  logic [BCD_W-1:0]  dig_q, dig_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              seen_q, seen_d;
  logic [3:0]        top;
  logic              skip, advance;

  assign top  = dig_q[BCD_W-1 -: 4];
  // leading zeros are dropped, the units digit always goes out
  assign skip = busy_q && !seen_q && (top == 4'd0) && (cnt_q != DCNT_W'(1));

  assign dig_o.valid = busy_q && !skip;
  assign dig_o.last  = (cnt_q == DCNT_W'(1));
  assign dig_o.ch    = CH_ZERO | {4'd0, top};

  assign advance = skip || (dig_o.valid && ready_i);

  always_comb begin
    dig_d  = dig_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    seen_d = seen_q;
    if (res_i.done) begin
      dig_d  = res_i.bcd;
      cnt_d  = DCNT_W'(NDIGITS);
      busy_d = 1'b1;
      seen_d = 1'b0;
    end else if (advance) begin
      dig_d = {dig_q[BCD_W-5:0], 4'd0};
      cnt_d = cnt_q - DCNT_W'(1);
      // once a digit went out, inner zeros are printed
      if (!skip) begin
        seen_d = 1'b1;
      end
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      seen_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      seen_q <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dig_q <= dig_d;
  end

endmodule

@@ rtl/format_string_decimal_printer_core.sv @@
`timescale 1ns / 1ps
// channel  dir  signals                                   word
// in_i     in   valid ready fmt_char[7:0] arg_value[15:0]  one format character + argument
// out_o    out  valid ready out_char[7:0] last_of_run      one emitted character
//
// plain characters, %c and %%: one cycle per input word when out_o does not stall,
//   output written at acceptance; %d: bit-serial shift-and-add-3 conversion (one
//   magnitude bit per cycle), digit hand-over, then the digit sequencer (one digit
//   per cycle unless out_o stalls, leading zeros skipped); the sign goes out early
// rst_ni clears the escape flag and all sequencing state; no clearing pass
// out_o stalls hold the output register; in_i is not ready while a %d runs
//   or while the output register holds a word that is not being taken
module format_string_decimal_printer_core import fdp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  fdp_in_if.sink    in_i,
  fdp_out_if.source out_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_DIGS = 2'd2;

  logic [1:0]        state_q, state_d;
  logic              esc_q, esc_d;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              out_last_q, out_last_d;

  logic              out_free, accept, push;
  logic [CHAR_W-1:0] push_ch;
  logic              push_last;
  logic              conv_start;
  logic [MAG_W-1:0]  raw, mag;
  bcd_res_t          bcd_res;
  dig_out_t          dig;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept     = in_i.valid && in_i.ready;

  assign raw = in_i.arg_value;
  assign mag = raw[MAG_W-1] ? MAG_W'(~raw + MAG_W'(1)) : raw;

  fdp_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .mag_i   (mag),
    .res_o   (bcd_res)
  );

  fdp_digits u_digits (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .res_i   (bcd_res),
    .ready_i (out_free),
    .dig_o   (dig)
  );

  always_comb begin
    state_d    = state_q;
    esc_d      = esc_q;
    push       = 1'b0;
    push_ch    = in_i.fmt_char;
    push_last  = 1'b1;
    conv_start = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!esc_q) begin
            if (in_i.fmt_char == CH_PCT) begin
              esc_d = 1'b1;
            end else if (in_i.fmt_char != CH_NUL) begin
              push = 1'b1;
            end
          end else begin
            esc_d = 1'b0;
            if (in_i.fmt_char == CH_D) begin
              conv_start = 1'b1;
              state_d    = ST_CONV;
              // sign goes out while the magnitude converts
              if (raw[MAG_W-1]) begin
                push      = 1'b1;
                push_ch   = CH_MINUS;
                push_last = 1'b0;
              end
            end else if (in_i.fmt_char == CH_C) begin
              push    = 1'b1;
              push_ch = raw[CHAR_W-1:0];
            end else if (in_i.fmt_char != CH_NUL) begin
              push = 1'b1;
            end
          end
        end
      end
      ST_CONV: begin
        if (bcd_res.done) begin
          state_d = ST_DIGS;
        end
      end
      ST_DIGS: begin
        if (dig.valid && out_free) begin
          push      = 1'b1;
          push_ch   = dig.ch;
          push_last = dig.last;
          if (dig.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (push) begin
      out_valid_d = 1'b1;
      out_char_d  = push_ch;
      out_last_d  = push_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      esc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      esc_q       <= esc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.out_char    = out_char_q;
  assign out_o.last_of_run = out_last_q;

  a_esc_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && esc_q |=> !esc_q)
    else $error("escape flag not cleared after conversion character");

  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIGS && push && push_last |=> state_q == ST_IDLE)
    else $error("decimal run did not end on its last digit");

  a_no_push_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CONV |-> !push && !dig.valid)
    else $error("word written while conversion still running");

endmodule

@@ sim/format_string_decimal_printer_core_tb.sv @@
`timescale 1ns / 1ps
module format_string_decimal_printer_core_tb;
  import fdp_pkg::*;

  localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
  localparam logic [CHAR_W-1:0] CH_UPPER = 8'h41;
  localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
  localparam int RANDOM_WORDS   = 200;
  localparam int BURST_WORDS    = 90;
  localparam int SETTLE_CYCLES  = 40;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } printed_char_t;

  logic clk_i;
  logic rst_ni;

  fdp_in_if  in_bus ();
  fdp_out_if out_bus ();

  format_string_decimal_printer_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  printed_char_t expected_chars[$];
  logic          escape_armed;
  bit            in_gaps_on;
  bit            out_stalls_on;
  int            errors;
  int            words_sent;
  int            chars_checked;
  int            decimals_printed;
  int            max_run_seen;

  always #5 clk_i = ~clk_i;

  // own view of the formatter: appends what one format word should print
  function automatic void predict_printout(input logic [CHAR_W-1:0] ch,
                                           input logic [ARG_W-1:0] arg);
    printed_char_t run[$];
    printed_char_t pc;
    logic [CHAR_W-1:0] digit_buf[$];
    int value;
    int mag;
    pc.last = 1'b0;
    if (!escape_armed) begin
      if (ch == CH_PCT) begin
        escape_armed = 1'b1;
      end else if (ch != CH_NUL) begin
        pc.ch = ch;
        run.push_back(pc);
      end
    end else begin
      escape_armed = 1'b0;
      if (ch == CH_D) begin
        decimals_printed++;
        value = $signed(arg);
        if (value < 0) begin
          pc.ch = CH_MINUS;
          run.push_back(pc);
          mag = -value;
        end else begin
          mag = value;
        end
        do begin
          digit_buf.push_front(CH_ZERO + CHAR_W'(mag % 10));
          mag = mag / 10;
        end while (mag != 0);
        foreach (digit_buf[i]) begin
          pc.ch = digit_buf[i];
          run.push_back(pc);
        end
      end else if (ch == CH_C) begin
        pc.ch = arg[CHAR_W-1:0];
        run.push_back(pc);
      end else if (ch != CH_NUL) begin
        // a literal percent and unknown conversions both echo the character
        pc.ch = ch;
        run.push_back(pc);
      end
    end
    if (run.size() != 0) begin
      run[run.size()-1].last = 1'b1;
      if (run.size() > max_run_seen) max_run_seen = run.size();
    end
    foreach (run[i]) expected_chars.push_back(run[i]);
  endfunction

  task automatic send_word(input logic [CHAR_W-1:0] ch, input logic [ARG_W-1:0] arg);
    int gap;
    gap = in_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.valid     <= 1'b1;
    in_bus.fmt_char  <= ch;
    in_bus.arg_value <= arg;
    predict_printout(ch, arg);
    do @(posedge clk_i); while (!in_bus.ready);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_bus.valid <= 1'b0;
  endtask

  function automatic logic [ARG_W-1:0] pick_arg();
    int v;
    case ($urandom_range(0, 7))
      0: pick_arg = 16'h8000;
      1: pick_arg = 16'h7fff;
      2: pick_arg = 16'hffff;
      3: pick_arg = 16'h0000;
      4, 5: begin
        v = int'($urandom_range(0, 2000)) - 1000;
        pick_arg = v[ARG_W-1:0];
      end
      default: pick_arg = ARG_W'($urandom);
    endcase
  endfunction

  // one piece of a format string: a plain character, a conversion or noise
  task automatic send_random_piece();
    logic [CHAR_W-1:0] ch;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        ch = CHAR_W'($urandom_range(8'h20, 8'h7e));
        send_word(ch, ARG_W'($urandom));
      end
      3, 4, 5: begin
        send_word(CH_PCT, ARG_W'($urandom));
        send_word(CH_D, pick_arg());
      end
      6: begin
        send_word(CH_PCT, ARG_W'($urandom));
        send_word(CH_C, ARG_W'($urandom));
      end
      7: begin
        send_word(CH_PCT, ARG_W'($urandom));
        send_word(CH_PCT, ARG_W'($urandom));
      end
      8: begin
        // broken escape: unknown conversion or end of string
        send_word(CH_PCT, ARG_W'($urandom));
        ch = ($urandom_range(0, 2) == 0) ? CH_NUL : CHAR_W'($urandom);
        send_word(ch, ARG_W'($urandom));
      end
      default: send_word(CHAR_W'($urandom), ARG_W'($urandom));
    endcase
  endtask

  task automatic test_directed_cases();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    send_word(CH_UPPER, 16'h0000);
    send_word(CH_NUL, 16'hffff);     // end of string, nothing printed
    send_word(8'hff, 16'h7fff);
    send_word(8'h80, 16'h8000);
    send_word(CH_PCT, 16'h1234);
    send_word(CH_D, 16'h0000);       // zero prints a single digit
    send_word(CH_PCT, 16'h0000);
    send_word(CH_D, 16'h7fff);
    send_word(CH_PCT, 16'h0000);
    send_word(CH_D, 16'h8000);       // most negative value, longest run
    send_word(CH_PCT, 16'h0000);
    send_word(CH_D, 16'hffff);
    send_word(CH_PCT, 16'h0000);
    send_word(CH_D, 16'd10000);
    send_word(CH_PCT, 16'h0000);
    send_word(CH_C, 16'habcd);       // only the low byte is printed
    send_word(CH_PCT, 16'h0000);
    send_word(CH_PCT, 16'h5555);
    send_word(CH_PCT, 16'h0000);
    send_word(CH_S, 16'haaaa);       // no string support, echoed
    send_word(CH_PCT, 16'h0000);
    send_word(CH_NUL, 16'h0000);     // escape dropped silently
    send_word(CH_BANG, 16'h0000);
  endtask

  task automatic test_random_strings();
    int target;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      repeat (8) send_random_piece();
    end
  endtask

  task automatic test_back_to_back();
    int target;
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    target = words_sent + BURST_WORDS;
    while (words_sent < target) send_random_piece();
  endtask

  task automatic wait_until_drained();
    stop_sending();
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // output side: random stalls when enabled, checks every word against the oldest prediction
  initial begin
    int stall;
    printed_char_t want;
    out_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = out_stalls_on ? $urandom_range(0, 7) : 0;
      if (stall != 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_bus.valid && out_bus.ready));
      chars_checked++;
      if (expected_chars.size() == 0) begin
        $error("unexpected word: out_char %h last_of_run %b",
               out_bus.out_char, out_bus.last_of_run);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_bus.out_char !== want.ch) begin
          $error("out_char: expected %h, got %h", want.ch, out_bus.out_char);
          errors++;
        end
        if (out_bus.last_of_run !== want.last) begin
          $error("last_of_run: expected %b, got %b", want.last, out_bus.last_of_run);
          errors++;
        end
      end
      @(negedge clk_i);
    end
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.fmt_char  = '0;
    in_bus.arg_value = '0;
    escape_armed     = 1'b0;
    in_gaps_on       = 1'b1;
    out_stalls_on    = 1'b1;
    errors           = 0;
    words_sent       = 0;
    chars_checked    = 0;
    decimals_printed = 0;
    max_run_seen     = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_strings();
    test_back_to_back();
    wait_until_drained();

    $display("sent %0d format words, checked %0d printed characters", words_sent,
             chars_checked);
    $display("%0d decimal conversions, longest run %0d characters", decimals_printed,
             max_run_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
